// File: design/fdf_pkg.sv
// shared constants and payload types of the direct-form fir filter
package fdf_pkg;

   // sizes
   localparam int MAX_TAPS        = 2048;
   localparam int ADDR_WIDTH      = $clog2(MAX_TAPS);
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC       = COEF_WIDTH - 1;
   localparam int TAP_COUNT_WIDTH = 12;
   localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH       = PROD_WIDTH + ADDR_WIDTH + 1;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // request payload
   typedef struct packed {
      logic                           req_type;
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic [ADDR_WIDTH-1:0]          coef_index;
      logic signed [COEF_WIDTH-1:0]   coef_value;
      logic                           block_end;
   } req_item_type;

   // result payload
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           block_end_out;
   } rsp_item_type;

   // controls from the sequencer to the mac unit
   typedef struct packed {
      logic start;
      logic data_valid;
   } mac_ctrl_type;

endpackage

// File: design/fir_filter_direct_form.sv
// direct-form fir filter: sequencer, history and coefficient memories
//
//  channel   dir  handshake               payload
//  req       in   req_valid / req_stall   req_item (sample or coefficient write)
//  rsp       out  rsp_valid / rsp_stall   rsp_item (one per sample request)
//  csr       in   csr_write_en            csr_write_data (tap count)
//
// a coefficient write is taken without leaving the idle state; a sample is worked
// by the single multiply-accumulate unit reading one tap per cycle from the two
// memories.
// after reset both memories are swept to zero, with req_stall high.
// a finished result waits in the output register while the next request is taken.
module fir_filter_direct_form (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fdf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fdf_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_en,
   input  logic [fdf_pkg::TAP_COUNT_WIDTH-1:0] csr_write_data
);
   import fdf_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MAC   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [TAP_COUNT_WIDTH-1:0] TAP_LIMIT = TAP_COUNT_WIDTH'(MAX_TAPS);

   // memories
   logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
   logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];

   logic [2:0]                     state_ff, state_in;
   logic [ADDR_WIDTH-1:0]          clr_addr_ff, clr_addr_in;
   logic [ADDR_WIDTH-1:0]          write_pos_ff, write_pos_in;
   logic [ADDR_WIDTH-1:0]          base_ff, base_in;
   logic [TAP_COUNT_WIDTH-1:0]     tap_count_ff;
   logic [TAP_COUNT_WIDTH-1:0]     taps_ff, taps_in;
   logic [TAP_COUNT_WIDTH-1:0]     iss_cnt_ff, iss_cnt_in;
   logic                           rd_vld_ff;
   logic                           block_end_ff, block_end_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_item_type                   rsp_item_ff;

   logic                           req_take;
   logic                           issue;
   logic                           out_load;
   logic [TAP_COUNT_WIDTH-1:0]     taps_now;
   logic [ADDR_WIDTH-1:0]          hist_rd_addr;
   logic signed [SAMPLE_WIDTH-1:0] hist_rd_ff;
   logic signed [COEF_WIDTH-1:0]   coef_rd_ff;

   logic                           hist_we, coef_we;
   logic [ADDR_WIDTH-1:0]          hist_wa, coef_wa;
   logic signed [SAMPLE_WIDTH-1:0] hist_wd;
   logic signed [COEF_WIDTH-1:0]   coef_wd;

   mac_ctrl_type                   mac_ctrl;
   logic                           mac_busy;
   logic signed [SAMPLE_WIDTH-1:0] mac_result;

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
      end else if (csr_write_en) begin
         tap_count_ff <= csr_write_data;
      end
   end

   assign taps_now  = (tap_count_ff > TAP_LIMIT) ? TAP_LIMIT : tap_count_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign issue     = (state_ff == ST_MAC);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      write_pos_in = write_pos_ff;
      base_in      = base_ff;
      taps_in      = taps_ff;
      iss_cnt_in   = iss_cnt_ff;
      block_end_in = block_end_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_WIDTH'(1);
            if (clr_addr_ff == ADDR_WIDTH'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && (req_item.req_type == REQ_SAMPLE)) begin
               base_in      = write_pos_ff;
               write_pos_in = write_pos_ff + ADDR_WIDTH'(1);
               taps_in      = taps_now;
               iss_cnt_in   = '0;
               block_end_in = req_item.block_end;
               state_in     = (taps_now == '0) ? ST_DONE : ST_MAC;
            end
         end
         ST_MAC: begin
            iss_cnt_in = iss_cnt_ff + TAP_COUNT_WIDTH'(1);
            if (iss_cnt_ff == taps_ff - TAP_COUNT_WIDTH'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         write_pos_ff <= '0;
         iss_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         write_pos_ff <= write_pos_in;
         iss_cnt_ff   <= iss_cnt_in;
         rd_vld_ff    <= issue;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      taps_ff      <= taps_in;
      block_end_ff <= block_end_in;
   end

   // memory write ports, shared by the clearing sweep and requests
   always_comb begin
      hist_we = 1'b0;
      hist_wa = write_pos_ff;
      hist_wd = req_item.sample_in;
      coef_we = 1'b0;
      coef_wa = req_item.coef_index;
      coef_wd = req_item.coef_value;
      if (state_ff == ST_CLEAR) begin
         hist_we = 1'b1;
         hist_wa = clr_addr_ff;
         hist_wd = '0;
         coef_we = 1'b1;
         coef_wa = clr_addr_ff;
         coef_wd = '0;
      end else if (req_take) begin
         // an 11-bit index always lands inside the coefficient memory
         hist_we = (req_item.req_type == REQ_SAMPLE);
         coef_we = (req_item.req_type == REQ_COEF);
      end
   end

   // newest sample sits at base, older ones below it
   assign hist_rd_addr = base_ff - iss_cnt_ff[ADDR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= coef_wd;
      end
      coef_rd_ff <= coef_mem[iss_cnt_ff[ADDR_WIDTH-1:0]];
   end

   // multiply-accumulate unit
   assign mac_ctrl.start      = req_take && (req_item.req_type == REQ_SAMPLE);
   assign mac_ctrl.data_valid = rd_vld_ff;

   fdf_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .hist_data (hist_rd_ff),
      .coef_data (coef_rd_ff),
      .busy      (mac_busy),
      .result    (mac_result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_item_ff.sample_out    <= mac_result;
         rsp_item_ff.block_end_out <= block_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: design/fdf_mac.sv
// multiply-accumulate unit with floor shift and output saturation
module fdf_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fdf_pkg::mac_ctrl_type                  ctrl,
   input  logic signed [fdf_pkg::SAMPLE_WIDTH-1:0] hist_data,
   input  logic signed [fdf_pkg::COEF_WIDTH-1:0]   coef_data,
   output logic                                   busy,
   output logic signed [fdf_pkg::SAMPLE_WIDTH-1:0] result
);
   import fdf_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] OUT_MAX =
      ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH-1:0] OUT_MIN = -OUT_MAX - ACC_WIDTH'(1);

   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                         prod_vld_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic signed [ACC_WIDTH-1:0]  shifted;

   // product stage
   assign prod_in = hist_data * coef_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.data_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.data_valid) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage, cleared at the start of each sample
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign busy = prod_vld_ff;

   // floor shift and clamp to sample range
   assign shifted = acc_ff >>> COEF_FRAC;

   always_comb begin
      if (shifted > OUT_MAX) begin
         result = OUT_MAX[SAMPLE_WIDTH-1:0];
      end else if (shifted < OUT_MIN) begin
         result = OUT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         result = shifted[SAMPLE_WIDTH-1:0];
      end
   end

endmodule
